>>> src/dfpm_pkg.sv
// ----------------------------------------------------------------------------
// dfpm_pkg: shared types and constants
// Widths, the decimal scale divisor and the array types used by the
// multiply pipeline stages.
// ----------------------------------------------------------------------------
package dfpm_pkg;

  localparam int OPER_LIMBS = 6;
  localparam int LIMB_W     = 32;
  localparam int PP_W       = 2 * LIMB_W;
  localparam int ROW_W      = 224;
  localparam int PAIR_W     = 256;
  localparam int PART_W     = 320;
  localparam int PROD_W     = 384;
  localparam int QUO_W      = 291;
  localparam int REM_W      = 94;

  // Long division by the scale works on 16-bit quotient digits. The top 80
  // product bits are below the divisor and seed the remainder, so 19 digit
  // steps cover the remaining 304 bits.
  localparam int DIG_W      = 16;
  localparam int STEPS      = 19;
  localparam int WORK_W     = STEPS * DIG_W;
  localparam int CUR_W      = REM_W + DIG_W;
  localparam int EST_W      = LIMB_W + 17;
  localparam int MUL_W      = DIG_W + LIMB_W;

  // Ten to the 28th, the fixed-point scale.
  localparam logic [REM_W-1:0] DIVISOR = 94'd10000000000000000000000000000;

  // floor(2^110 / 10^28): scales the top 32 bits of a partial dividend into a
  // digit estimate that is at most one below the true digit.
  localparam logic [16:0] RECIP = 17'd129807;

  typedef logic [LIMB_W-1:0]                             limb_t;
  typedef logic [OPER_LIMBS-1:0][LIMB_W-1:0]             oper_t;
  typedef logic [OPER_LIMBS-1:0][OPER_LIMBS-1:0][PP_W-1:0] pp_arr_t;
  typedef logic [PROD_W-1:0]                             prod_t;
  typedef logic [QUO_W-1:0]                              quo_t;
  typedef logic [REM_W-1:0]                              rem_t;
  typedef logic [WORK_W-1:0]                             work_t;

endpackage

>>> src/dfpm_pp.sv
// ----------------------------------------------------------------------------
// dfpm_pp: partial product stage
// Forms all 36 limb-by-limb 32x32 products of the two operands in parallel
// and registers them.
// ----------------------------------------------------------------------------
module dfpm_pp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_in,
  input  dfpm_pkg::oper_t  a_in,
  input  dfpm_pkg::oper_t  b_in,
  output logic             valid_out,
  output dfpm_pkg::pp_arr_t pp_out
);

  logic              valid_r;
  dfpm_pkg::pp_arr_t pp_r;
  dfpm_pkg::pp_arr_t pp_nxt;

  // Index [i][k] holds b limb i times a limb k.
  always_comb begin
    for (int i = 0; i < dfpm_pkg::OPER_LIMBS; i++) begin
      for (int k = 0; k < dfpm_pkg::OPER_LIMBS; k++) begin
        pp_nxt[i][k] = dfpm_pkg::PP_W'(a_in[k]) * dfpm_pkg::PP_W'(b_in[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= pp_nxt;
  end

  assign valid_out = valid_r;
  assign pp_out    = pp_r;

endmodule

>>> src/dfpm_sum.sv
// ----------------------------------------------------------------------------
// dfpm_sum: partial product accumulation
// Adds the partial products into the exact 384-bit product over four
// registered adder stages.
// ----------------------------------------------------------------------------
module dfpm_sum (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_in,
  input  dfpm_pkg::pp_arr_t pp_in,
  output logic              valid_out,
  output dfpm_pkg::prod_t   prod_out
);

  logic [3:0] valid_r;

  logic [dfpm_pkg::OPER_LIMBS-1:0][dfpm_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [2:0][dfpm_pkg::PAIR_W-1:0] pair_r, pair_nxt;
  logic [dfpm_pkg::PART_W-1:0]      part_r, part_nxt;
  logic [dfpm_pkg::PAIR_W-1:0]      hold_r;
  dfpm_pkg::prod_t                  prod_r, prod_nxt;

  // Each row splits into even and odd limb products, which do not overlap
  // within their own group, so a row is a single add.
  always_comb begin
    for (int i = 0; i < dfpm_pkg::OPER_LIMBS; i++) begin
      row_nxt[i] = dfpm_pkg::ROW_W'({pp_in[i][4], pp_in[i][2], pp_in[i][0]})
                 + {pp_in[i][5], pp_in[i][3], pp_in[i][1], 32'b0};
    end
    for (int j = 0; j < 3; j++) begin
      pair_nxt[j] = dfpm_pkg::PAIR_W'(row_r[2*j]) + {row_r[2*j+1], 32'b0};
    end
    part_nxt = dfpm_pkg::PART_W'(pair_r[0]) + {pair_r[1], 64'b0};
    prod_nxt = dfpm_pkg::PROD_W'(part_r) + {hold_r, 128'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[2:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    row_r  <= row_nxt;
    pair_r <= pair_nxt;
    part_r <= part_nxt;
    hold_r <= pair_r[2];
    prod_r <= prod_nxt;
  end

  assign valid_out = valid_r[3];
  assign prod_out  = prod_r;

endmodule

>>> src/dfpm_div_stage.sv
// ----------------------------------------------------------------------------
// dfpm_div_stage: one radix-2^16 long-division step by the scale
// Brings the next 16 dividend bits into the remainder, estimates the quotient
// digit by a reciprocal multiply, subtracts the digit's divisor multiple and
// corrects the digit by one when the remainder is still too large. Three
// register stages.
// ----------------------------------------------------------------------------
module dfpm_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  dfpm_pkg::rem_t  rem_in,
  input  dfpm_pkg::work_t work_in,
  output logic            valid_out,
  output dfpm_pkg::rem_t  rem_out,
  output dfpm_pkg::work_t work_out
);

  logic [2:0]                    valid_r;
  logic [dfpm_pkg::CUR_W-1:0]    cur_nxt, cur_a_r, cur_b_r;
  logic [dfpm_pkg::LIMB_W-1:0]   top_nxt;
  logic [dfpm_pkg::EST_W-1:0]    est_nxt;
  logic [dfpm_pkg::DIG_W-1:0]    q_nxt, q_a_r, q_b_r;
  logic [dfpm_pkg::MUL_W-1:0]    m0_nxt, m1_nxt, m2_nxt, m0_r, m1_r, m2_r;
  logic [dfpm_pkg::CUR_W-1:0]    qd, diff0;
  logic [dfpm_pkg::CUR_W:0]      diff1;
  logic                          fits;
  dfpm_pkg::work_t               work_a_r, work_b_r, work_r, work_nxt;
  dfpm_pkg::rem_t                rem_r, rem_nxt;

  always_comb begin
    // Estimate: the true digit is this value or one more.
    cur_nxt = {rem_in, work_in[dfpm_pkg::WORK_W-1 -: dfpm_pkg::DIG_W]};
    top_nxt = cur_nxt[dfpm_pkg::CUR_W-1 -: dfpm_pkg::LIMB_W];
    est_nxt = dfpm_pkg::EST_W'(top_nxt) * dfpm_pkg::EST_W'(dfpm_pkg::RECIP);
    q_nxt   = est_nxt[dfpm_pkg::EST_W-2 -: dfpm_pkg::DIG_W];

    // Divisor multiple, one 32-bit divisor limb at a time.
    m0_nxt = dfpm_pkg::MUL_W'(q_a_r) * dfpm_pkg::MUL_W'(dfpm_pkg::DIVISOR[31:0]);
    m1_nxt = dfpm_pkg::MUL_W'(q_a_r) * dfpm_pkg::MUL_W'(dfpm_pkg::DIVISOR[63:32]);
    m2_nxt = dfpm_pkg::MUL_W'(q_a_r)
           * dfpm_pkg::MUL_W'(dfpm_pkg::DIVISOR[dfpm_pkg::REM_W-1:64]);

    // Both candidate remainders are formed side by side; the second one is
    // taken when it does not go negative.
    qd    = dfpm_pkg::CUR_W'(m0_r) + dfpm_pkg::CUR_W'({m1_r, 32'b0})
          + dfpm_pkg::CUR_W'({m2_r, 64'b0});
    diff0 = cur_b_r - qd;
    diff1 = {1'b0, cur_b_r} - {1'b0, qd}
          - (dfpm_pkg::CUR_W+1)'(dfpm_pkg::DIVISOR);
    fits  = !diff1[dfpm_pkg::CUR_W];
    rem_nxt  = fits ? dfpm_pkg::REM_W'(diff1) : dfpm_pkg::REM_W'(diff0);
    work_nxt = {work_b_r[dfpm_pkg::WORK_W-1:dfpm_pkg::DIG_W],
                q_b_r + dfpm_pkg::DIG_W'(fits)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[1:0], valid_in};
    end
  end

  always_ff @(posedge clk) begin
    cur_a_r  <= cur_nxt;
    q_a_r    <= q_nxt;
    work_a_r <= {work_in[dfpm_pkg::WORK_W-dfpm_pkg::DIG_W-1:0], {dfpm_pkg::DIG_W{1'b0}}};
    cur_b_r  <= cur_a_r;
    q_b_r    <= q_a_r;
    work_b_r <= work_a_r;
    m0_r     <= m0_nxt;
    m1_r     <= m1_nxt;
    m2_r     <= m2_nxt;
    rem_r    <= rem_nxt;
    work_r   <= work_nxt;
  end

  assign valid_out = valid_r[2];
  assign rem_out   = rem_r;
  assign work_out  = work_r;

endmodule

>>> src/decimal_fixed_point_multiply_core.sv
// ----------------------------------------------------------------------------
// decimal_fixed_point_multiply_core: 28-digit fixed-point multiply
// Throughput: one request per cycle; busy is always low and never stalls.
// One partial-product stage and four adder stages form the exact product; then
// 19 radix-2^16 division steps of three stages each (digit estimate, divisor
// multiple, subtract and correct) set the rest of the latency.
// Reset (synchronous, rst_n low) clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
module decimal_fixed_point_multiply_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_a_mid,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [63:0] in_b_mid,
  input  logic [63:0] in_b_high,
  output logic        out_valid,
  output logic [63:0] out_q_part0,
  output logic [63:0] out_q_part1,
  output logic [63:0] out_q_part2,
  output logic [63:0] out_q_part3,
  output logic [34:0] out_q_part4
);

  // The pipeline moves every cycle and the receiver never pushes back, so a
  // request is taken whenever start is high.
  assign busy = 1'b0;

  dfpm_pkg::oper_t   a_limbs, b_limbs;
  logic              accept;
  logic              pp_valid;
  dfpm_pkg::pp_arr_t pp;
  logic              prod_valid;
  dfpm_pkg::prod_t   prod;

  assign accept  = start && !busy;
  assign a_limbs = {in_a_high, in_a_mid, in_a_low};
  assign b_limbs = {in_b_high, in_b_mid, in_b_low};

  // First stage: all limb products at once.
  dfpm_pp u_pp (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (accept),
    .a_in      (a_limbs),
    .b_in      (b_limbs),
    .valid_out (pp_valid),
    .pp_out    (pp)
  );

  // Four adder stages fold the partial products into the exact product.
  dfpm_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (pp_valid),
    .pp_in     (pp),
    .valid_out (prod_valid),
    .prod_out  (prod)
  );

  // Division by ten to the 28th. The top 80 product bits are below the
  // divisor, so they seed the partial remainder directly and the low 304 bits
  // are handled 16 at a time. Each step shifts one 16-bit dividend digit out
  // of the top of the work word and its quotient digit into the bottom; after
  // the last step the work word is the quotient.
  logic            div_valid [dfpm_pkg::STEPS+1];
  dfpm_pkg::rem_t  div_rem   [dfpm_pkg::STEPS+1];
  dfpm_pkg::work_t div_work  [dfpm_pkg::STEPS+1];

  assign div_valid[0] = prod_valid;
  assign div_rem[0]   = dfpm_pkg::REM_W'(prod[dfpm_pkg::PROD_W-1:dfpm_pkg::WORK_W]);
  assign div_work[0]  = prod[dfpm_pkg::WORK_W-1:0];

  for (genvar s = 0; s < dfpm_pkg::STEPS; s++) begin : g_div
    dfpm_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (div_valid[s]),
      .rem_in    (div_rem[s]),
      .work_in   (div_work[s]),
      .valid_out (div_valid[s+1]),
      .rem_out   (div_rem[s+1]),
      .work_out  (div_work[s+1])
    );
  end

  // The last division stage is the output register.
  assign out_valid   = div_valid[dfpm_pkg::STEPS];
  assign out_q_part0 = div_work[dfpm_pkg::STEPS][63:0];
  assign out_q_part1 = div_work[dfpm_pkg::STEPS][127:64];
  assign out_q_part2 = div_work[dfpm_pkg::STEPS][191:128];
  assign out_q_part3 = div_work[dfpm_pkg::STEPS][255:192];
  assign out_q_part4 = div_work[dfpm_pkg::STEPS][290:256];

  // A reset cycle leaves no result in flight.
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // The product's top bits must already be below the divisor to seed it.
  a_seed_range: assert property (@(posedge clk) disable iff (!rst_n)
    prod_valid |-> (div_rem[0] < dfpm_pkg::DIVISOR))
    else $error("division seed not below divisor");

  // The final remainder of a delivered result is a proper remainder.
  a_final_rem: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (div_rem[dfpm_pkg::STEPS] < dfpm_pkg::DIVISOR))
    else $error("final remainder not below divisor");

  // The quotient always fits in 291 bits, so the spare top digit bits are zero.
  a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (div_work[dfpm_pkg::STEPS][dfpm_pkg::WORK_W-1:dfpm_pkg::QUO_W] == '0))
    else $error("quotient wider than 291 bits");

endmodule

>>> bench/dfpm_checker.sv
// ----------------------------------------------------------------------------
// dfpm_checker: scaled product predictor and result comparator
// Watches accepted requests, computes floor(a*b / 10^28) for each one and
// compares every strobed result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module dfpm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] in_a_low,
  input  logic [63:0] in_a_mid,
  input  logic [63:0] in_a_high,
  input  logic [63:0] in_b_low,
  input  logic [63:0] in_b_mid,
  input  logic [63:0] in_b_high,
  input  logic        out_valid,
  input  logic [63:0] out_q_part0,
  input  logic [63:0] out_q_part1,
  input  logic [63:0] out_q_part2,
  input  logic [63:0] out_q_part3,
  input  logic [34:0] out_q_part4,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  dfpm_pkg::quo_t scaled_q[$];

  function automatic dfpm_pkg::quo_t scaled_product(logic [191:0] a, logic [191:0] b);
    dfpm_pkg::prod_t p;
    p = dfpm_pkg::prod_t'(a) * dfpm_pkg::prod_t'(b);
    p = p / dfpm_pkg::prod_t'(dfpm_pkg::DIVISOR);
    return p[dfpm_pkg::QUO_W-1:0];
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    dfpm_pkg::quo_t want, got;
    if (rst_n && start && !busy)
      scaled_q.push_back(scaled_product({in_a_high, in_a_mid, in_a_low},
                                        {in_b_high, in_b_mid, in_b_low}));
    if (rst_n && out_valid) begin
      got = {out_q_part4, out_q_part3, out_q_part2, out_q_part1, out_q_part0};
      if (scaled_q.size() == 0) begin
        fail_count <= fail_count + 1;
        $display("%0t: unexpected result %h", $realtime, got);
      end else begin
        want = scaled_q.pop_front();
        if (want[63:0] !== out_q_part0 || want[127:64] !== out_q_part1 ||
            want[191:128] !== out_q_part2 || want[255:192] !== out_q_part3 ||
            want[290:256] !== out_q_part4) begin
          fail_count <= fail_count + 1;
          $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
        end
      end
    end
    pending <= scaled_q.size();
  end
endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: decimal fixed-point multiply regression
// Drives directed corner operands and bursty random requests into the core
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 62;
  localparam int N_RANDOM  = 650;
  localparam int CYCLE_CAP = 200000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [63:0] in_a_low, in_a_mid, in_a_high, in_b_low, in_b_mid, in_b_high;
  logic        out_valid;
  logic [63:0] out_q_part0, out_q_part1, out_q_part2, out_q_part3;
  logic [34:0] out_q_part4;
  int          fail_count;
  int          pending;
  int          cycles;

  decimal_fixed_point_multiply_core dut (.*);
  dfpm_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The cycle counter is the watchdog: it ends a run that hangs.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("decimal_fixed_point_multiply_core regression: fail");
        $finish;
      end
    end
  end

  // Picks one 64-bit word, often a corner value so carries run long.
  function automatic logic [63:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'd1;
      3: return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Puts one request on the ports and holds it until it is taken.
  task automatic send_request(logic [63:0] al, am, ah, bl, bm, bh);
    start     <= 1'b1;
    in_a_low  <= al;
    in_a_mid  <= am;
    in_a_high <= ah;
    in_b_low  <= bl;
    in_b_mid  <= bm;
    in_b_high <= bh;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic [63:0] ones;
    logic [63:0] w[6];
    int n;
    int burst;
    int wait_cnt;
    ones = '1;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_a_low  = '0;
    in_a_mid  = '0;
    in_a_high = '0;
    in_b_low  = '0;
    in_b_mid  = '0;
    in_b_high = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: zero, one unit, the scale itself, and full-width operands
    // whose quotient fills every bit of the top part.
    send_request(0, 0, 0, 0, 0, 0);
    send_request(ones, ones, ones, ones, ones, ones);
    send_request(ones, ones, ones, 0, 0, 0);
    send_request(1, 0, 0, 1, 0, 0);
    send_request(64'h3e25_0261_1000_0000, 64'h0000_0000_204f_ce5e, 0,
                 1, 0, 0);
    send_request(ones, 0, 0, ones, 0, 0);
    send_request(0, ones, 0, 0, ones, 0);
    send_request(0, 0, ones, 0, 0, ones);
    send_request(0, 0, 64'h8000_0000_0000_0000, 0, 0, 64'h8000_0000_0000_0000);
    send_request(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(64'd9999999999, 0, 0, 64'd9999999999, 0, 0);
    go_idle();

    // The sender holds off here until the pipeline has drained, or until the wait limit runs out.
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 4 * LATENCY) begin
      @(posedge clk);
      wait_cnt++;
    end

    // Random part: bursts of back-to-back requests, with random gaps between most bursts.
    n = 0;
    while (n < N_RANDOM) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n < N_RANDOM; i++) begin
        foreach (w[k]) w[k] = pick_word();
        send_request(w[0], w[1], w[2], w[3], w[4], w[5]);
        n++;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    go_idle();

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 4 * LATENCY) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 20) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("decimal_fixed_point_multiply_core regression: pass");
    end else begin
      $display("decimal_fixed_point_multiply_core regression: fail");
    end
    $finish;
  end
endmodule
